// ----- hw/rtl/asu_pkg.sv -----
// ----------------------------------------------------------------------------
// asu_pkg
// Shared types, codes and sizes of the ARM subset execute unit.
// ----------------------------------------------------------------------------
package asu_pkg;

   localparam int REG_COUNT = 16;
   localparam int REG_AW    = $clog2(REG_COUNT);
   localparam int MEM_WORDS = 8;
   localparam int MEM_AW    = (MEM_WORDS > 1) ? $clog2(MEM_WORDS) : 1;
   localparam logic [31:0] MEM_OFF_MAX   = 32'(4 * (MEM_WORDS - 1));
   localparam logic [31:0] BASE_RESET    = 32'h0000_0100;

   localparam logic [3:0] FUNC_ADD = 4'd0;
   localparam logic [3:0] FUNC_SUB = 4'd1;
   localparam logic [3:0] FUNC_AND = 4'd2;
   localparam logic [3:0] FUNC_ORR = 4'd3;
   localparam logic [3:0] FUNC_EOR = 4'd4;
   localparam logic [3:0] FUNC_LSL = 4'd5;
   localparam logic [3:0] FUNC_LSR = 4'd6;
   localparam logic [3:0] FUNC_MOV = 4'd7;
   localparam logic [3:0] FUNC_MVN = 4'd8;
   localparam logic [3:0] FUNC_CMP = 4'd9;
   localparam logic [3:0] FUNC_LDR = 4'd10;
   localparam logic [3:0] FUNC_STR = 4'd11;
   localparam logic [3:0] FUNC_BNE = 4'd12;
   localparam logic [3:0] FUNC_BEQ = 4'd13;
   localparam logic [3:0] FUNC_BAL = 4'd14;

   localparam logic [2:0] COND_AL = 3'd0;
   localparam logic [2:0] COND_GT = 3'd1;
   localparam logic [2:0] COND_GE = 3'd2;
   localparam logic [2:0] COND_LT = 3'd3;
   localparam logic [2:0] COND_LE = 3'd4;
   localparam logic [2:0] COND_EQ = 3'd5;
   localparam logic [2:0] COND_NE = 3'd6;

   localparam logic [1:0] KIND_IMM = 2'd0;

   localparam logic [2:0] ST_EXECUTED         = 3'd0;
   localparam logic [2:0] ST_COND_FALSE       = 3'd1;
   localparam logic [2:0] ST_SKIPPED          = 3'd2;
   localparam logic [2:0] ST_OUT_OF_RANGE     = 3'd3;
   localparam logic [2:0] ST_BRANCH_TAKEN     = 3'd4;
   localparam logic [2:0] ST_BRANCH_NOT_TAKEN = 3'd5;

   typedef struct packed {
      logic [3:0]  func;
      logic [2:0]  cond;
      logic        set_flags;
      logic [3:0]  dest_reg;
      logic [1:0]  op2_kind;
      logic [31:0] op2_imm;
      logic [7:0]  line_label;
      logic [7:0]  branch_label;
      logic [31:0] opa;
      logic [31:0] opb;
   } exec_item_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [31:0] written_value;
      logic        wrote_register;
      logic        wrote_memory;
      logic [3:0]  nzcv;
   } exec_result_type;

   function automatic logic reg_in_range(input logic [3:0] idx);
      reg_in_range = ({2'b00, idx} < 6'(REG_COUNT));
   endfunction

endpackage

// ----- hw/rtl/asu_ram.sv -----
// ----------------------------------------------------------------------------
// asu_ram
// Generic RAM: one write port, two read ports with registered read data.
// ----------------------------------------------------------------------------
module asu_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr_a,
   input  logic [AW-1:0]    rd_addr_b,
   output logic [WIDTH-1:0] rd_data_a,
   output logic [WIDTH-1:0] rd_data_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_a_ff;
   logic [WIDTH-1:0] rd_data_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_a_ff <= mem_ff[rd_addr_a];
         rd_data_b_ff <= mem_ff[rd_addr_b];
      end
   end

   assign rd_data_a = rd_data_a_ff;
   assign rd_data_b = rd_data_b_ff;

endmodule

// ----- hw/rtl/asu_exec.sv -----
// ----------------------------------------------------------------------------
// asu_exec
// Execute stage: condition check, ALU, shifter, data memory, flags and
// branch-skip state. State advances on each execute transfer.
// ----------------------------------------------------------------------------
module asu_exec (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     fire,
   input  asu_pkg::exec_item_type   item,
   input  logic                     csr_we,
   input  logic [31:0]              csr_data,
   output asu_pkg::exec_result_type res
);

   logic [3:0]  flags_ff;
   logic        skipping_ff;
   logic [7:0]  awaited_ff;
   logic [31:0] base_ff;
   logic [31:0] dmem_ff [asu_pkg::MEM_WORDS];

   logic [3:0]  flags_in;
   logic        cond_ok;
   logic        label_match;
   logic        skip_hold;
   logic [31:0] a;
   logic [31:0] op2;
   logic [32:0] sum;
   logic [32:0] dif;
   logic [32:0] shl;
   logic [32:0] shr;
   logic        add_v;
   logic        sub_v;
   logic [31:0] off;
   logic        mem_ok;
   logic [asu_pkg::MEM_AW-1:0] mem_idx;
   logic [31:0] mem_rd;
   logic        taken;
   logic        mem_we;

   assign a   = item.opa;
   assign op2 = (item.op2_kind == asu_pkg::KIND_IMM) ? item.op2_imm : item.opb;
   assign sum = {1'b0, a} + {1'b0, op2};
   assign dif = {1'b0, a} - {1'b0, op2};
   assign shl = {1'b0, a} << op2[5:0];
   assign shr = {a, 1'b0} >> op2[5:0];
   assign add_v = (~(a[31] ^ op2[31])) & (a[31] ^ sum[31]);
   assign sub_v = (a[31] ^ op2[31]) & (a[31] ^ dif[31]);

   assign off     = op2 - base_ff;
   assign mem_ok  = (op2 >= base_ff) && (off <= asu_pkg::MEM_OFF_MAX);
   assign mem_idx = off[asu_pkg::MEM_AW+1:2];
   assign mem_rd  = dmem_ff[mem_idx];

   assign label_match = (item.line_label != 8'd0) && (item.line_label == awaited_ff);
   assign skip_hold   = skipping_ff && !label_match;

   always_comb begin
      logic n;
      logic z;
      logic v;
      n = flags_ff[3];
      z = flags_ff[2];
      v = flags_ff[0];
      case (item.cond)
         asu_pkg::COND_GT: cond_ok = !z && (n == v);
         asu_pkg::COND_GE: cond_ok = (n == v);
         asu_pkg::COND_LT: cond_ok = (n != v);
         asu_pkg::COND_LE: cond_ok = z || (n != v);
         asu_pkg::COND_EQ: cond_ok = z;
         asu_pkg::COND_NE: cond_ok = !z;
         default:          cond_ok = 1'b1;
      endcase
   end

   always_comb begin
      logic [31:0] r;
      logic        c_n;
      logic        v_n;
      logic        upd;
      r        = 32'd0;
      c_n      = flags_ff[1];
      v_n      = flags_ff[0];
      upd      = 1'b0;
      taken    = 1'b0;
      mem_we   = 1'b0;
      res.status         = asu_pkg::ST_EXECUTED;
      res.written_value  = 32'd0;
      res.wrote_register = 1'b0;
      res.wrote_memory   = 1'b0;
      if (skip_hold) begin
         res.status = asu_pkg::ST_SKIPPED;
      end else if (!cond_ok) begin
         res.status = asu_pkg::ST_COND_FALSE;
      end else begin
         case (item.func)
            asu_pkg::FUNC_ADD, asu_pkg::FUNC_SUB, asu_pkg::FUNC_AND, asu_pkg::FUNC_ORR,
            asu_pkg::FUNC_EOR, asu_pkg::FUNC_MOV, asu_pkg::FUNC_MVN,
            asu_pkg::FUNC_LSL, asu_pkg::FUNC_LSR: begin
               case (item.func)
                  asu_pkg::FUNC_ADD: begin
                     r   = sum[31:0];
                     c_n = sum[32];
                     v_n = add_v;
                  end
                  asu_pkg::FUNC_SUB: begin
                     r   = dif[31:0];
                     c_n = ~dif[32];
                     v_n = sub_v;
                  end
                  asu_pkg::FUNC_AND: r = a & op2;
                  asu_pkg::FUNC_ORR: r = a | op2;
                  asu_pkg::FUNC_EOR: r = a ^ op2;
                  asu_pkg::FUNC_MOV: r = op2;
                  asu_pkg::FUNC_MVN: r = ~op2;
                  asu_pkg::FUNC_LSL, asu_pkg::FUNC_LSR: begin
                     if (op2 == 32'd0) begin
                        r = a;
                     end else if (op2 <= 32'd32) begin
                        if (item.func == asu_pkg::FUNC_LSL) begin
                           r   = shl[31:0];
                           c_n = shl[32];
                        end else begin
                           r   = shr[32:1];
                           c_n = shr[0];
                        end
                     end else begin
                        r   = 32'd0;
                        c_n = 1'b0;
                     end
                  end
                  default: r = 32'd0;
               endcase
               res.written_value  = r;
               res.wrote_register = asu_pkg::reg_in_range(item.dest_reg);
               upd = item.set_flags;
            end
            asu_pkg::FUNC_CMP: begin
               r   = dif[31:0];
               c_n = ~dif[32];
               v_n = sub_v;
               res.written_value = r;
               upd = 1'b1;
            end
            asu_pkg::FUNC_LDR: begin
               if (!mem_ok) begin
                  res.status = asu_pkg::ST_OUT_OF_RANGE;
               end else begin
                  res.written_value  = mem_rd;
                  res.wrote_register = asu_pkg::reg_in_range(item.dest_reg);
               end
            end
            asu_pkg::FUNC_STR: begin
               if (!mem_ok) begin
                  res.status = asu_pkg::ST_OUT_OF_RANGE;
               end else begin
                  res.written_value = a;
                  res.wrote_memory  = 1'b1;
                  mem_we            = 1'b1;
               end
            end
            asu_pkg::FUNC_BNE, asu_pkg::FUNC_BEQ, asu_pkg::FUNC_BAL: begin
               taken = (item.func == asu_pkg::FUNC_BAL)
                    || ((item.func == asu_pkg::FUNC_BNE) && !flags_ff[2])
                    || ((item.func == asu_pkg::FUNC_BEQ) && flags_ff[2]);
               res.status = taken ? asu_pkg::ST_BRANCH_TAKEN
                                  : asu_pkg::ST_BRANCH_NOT_TAKEN;
            end
            default: r = 32'd0;
         endcase
      end
      flags_in = upd ? {r[31], (r == 32'd0), c_n, v_n} : flags_ff;
      res.nzcv = flags_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         flags_ff    <= 4'd0;
         skipping_ff <= 1'b0;
         awaited_ff  <= 8'd0;
         base_ff     <= asu_pkg::BASE_RESET;
         for (int i = 0; i < asu_pkg::MEM_WORDS; i++) begin
            dmem_ff[i] <= 32'd0;
         end
      end else begin
         if (csr_we) begin
            base_ff <= csr_data;
         end
         if (fire) begin
            flags_ff <= flags_in;
            if (taken) begin
               skipping_ff <= 1'b1;
               awaited_ff  <= item.branch_label;
            end else if (skipping_ff && label_match) begin
               skipping_ff <= 1'b0;
            end
            if (mem_we) begin
               dmem_ff[mem_idx] <= a;
            end
         end
      end
   end

endmodule

// ----- hw/rtl/arm_subset_execute_unit.sv -----
// ----------------------------------------------------------------------------
// arm_subset_execute_unit
// Executes one decoded ARM-subset instruction per transfer.
// ----------------------------------------------------------------------------
// Two-stage pipeline that sustains one instruction per cycle while the result
// side does not stall. Stage 1 captures the instruction together with the
// registered read of the two register-file ports (with forwarding from the
// instruction executing in the same cycle); stage 2 executes, updates the
// register file, data memory, flags and branch-skip state, and loads the
// result register. A result becomes valid once its instruction leaves stage 1
// and loads the result register; a result-side stall can hold it in stage 1.
// The base-address register may only be written while the unit is idle.
// ----------------------------------------------------------------------------
module arm_subset_execute_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [3:0]  req_func,
   input  logic [2:0]  req_cond,
   input  logic        req_set_flags,
   input  logic [3:0]  req_dest_reg,
   input  logic [3:0]  req_src_reg,
   input  logic [1:0]  req_op2_kind,
   input  logic [3:0]  req_op2_reg,
   input  logic [31:0] req_op2_imm,
   input  logic [7:0]  req_line_label,
   input  logic [7:0]  req_branch_label,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_status,
   output logic [31:0] rsp_written_value,
   output logic        rsp_wrote_register,
   output logic        rsp_wrote_memory,
   output logic        rsp_flag_n,
   output logic        rsp_flag_z,
   output logic        rsp_flag_c,
   output logic        rsp_flag_v,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [31:0] csr_memory_base_address
);

   logic        accept;
   logic        ex_fire;
   logic [3:0]  addr_a;

   logic        s1_valid_ff;
   logic [3:0]  s1_func_ff;
   logic [2:0]  s1_cond_ff;
   logic        s1_set_flags_ff;
   logic [3:0]  s1_dest_reg_ff;
   logic [1:0]  s1_op2_kind_ff;
   logic [31:0] s1_op2_imm_ff;
   logic [7:0]  s1_line_label_ff;
   logic [7:0]  s1_branch_label_ff;
   logic        a_live_ff;
   logic        b_live_ff;
   logic        a_fwd_ff;
   logic        b_fwd_ff;
   logic [31:0] fwd_data_ff;

   logic        reg_valid_ff [asu_pkg::REG_COUNT];
   logic        reg_we;
   logic [31:0] ram_a;
   logic [31:0] ram_b;

   asu_pkg::exec_item_type   item;
   asu_pkg::exec_result_type res;

   logic                     rsp_valid_ff;
   asu_pkg::exec_result_type rsp_ff;

   assign ex_fire   = s1_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = s1_valid_ff && !ex_fire;
   assign accept    = req_valid && !req_stall;
   assign csr_ready = 1'b1;

   assign addr_a = ((req_func == asu_pkg::FUNC_CMP) || (req_func == asu_pkg::FUNC_STR))
                 ? req_dest_reg : req_src_reg;
   assign reg_we = ex_fire && res.wrote_register;

   asu_ram #(
      .WIDTH (32),
      .DEPTH (asu_pkg::REG_COUNT)
   ) u_regfile (
      .clock     (clock),
      .wr_en     (reg_we),
      .wr_addr   (asu_pkg::REG_AW'(s1_dest_reg_ff)),
      .wr_data   (res.written_value),
      .rd_en     (accept),
      .rd_addr_a (asu_pkg::REG_AW'(addr_a)),
      .rd_addr_b (asu_pkg::REG_AW'(req_op2_reg)),
      .rd_data_a (ram_a),
      .rd_data_b (ram_b)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         for (int i = 0; i < asu_pkg::REG_COUNT; i++) begin
            reg_valid_ff[i] <= 1'b0;
         end
      end else begin
         if (accept) begin
            s1_valid_ff <= 1'b1;
         end else if (ex_fire) begin
            s1_valid_ff <= 1'b0;
         end
         if (reg_we) begin
            reg_valid_ff[asu_pkg::REG_AW'(s1_dest_reg_ff)] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_func_ff         <= req_func;
         s1_cond_ff         <= req_cond;
         s1_set_flags_ff    <= req_set_flags;
         s1_dest_reg_ff     <= req_dest_reg;
         s1_op2_kind_ff     <= req_op2_kind;
         s1_op2_imm_ff      <= req_op2_imm;
         s1_line_label_ff   <= req_line_label;
         s1_branch_label_ff <= req_branch_label;
         a_live_ff <= asu_pkg::reg_in_range(addr_a)
                   && reg_valid_ff[asu_pkg::REG_AW'(addr_a)];
         b_live_ff <= asu_pkg::reg_in_range(req_op2_reg)
                   && reg_valid_ff[asu_pkg::REG_AW'(req_op2_reg)];
         a_fwd_ff    <= reg_we && (s1_dest_reg_ff == addr_a);
         b_fwd_ff    <= reg_we && (s1_dest_reg_ff == req_op2_reg);
         fwd_data_ff <= res.written_value;
      end
   end

   always_comb begin
      item.func         = s1_func_ff;
      item.cond         = s1_cond_ff;
      item.set_flags    = s1_set_flags_ff;
      item.dest_reg     = s1_dest_reg_ff;
      item.op2_kind     = s1_op2_kind_ff;
      item.op2_imm      = s1_op2_imm_ff;
      item.line_label   = s1_line_label_ff;
      item.branch_label = s1_branch_label_ff;
      item.opa = a_fwd_ff ? fwd_data_ff : (a_live_ff ? ram_a : 32'd0);
      item.opb = b_fwd_ff ? fwd_data_ff : (b_live_ff ? ram_b : 32'd0);
   end

   asu_exec u_exec (
      .clock    (clock),
      .reset    (reset),
      .fire     (ex_fire),
      .item     (item),
      .csr_we   (csr_valid && csr_ready),
      .csr_data (csr_memory_base_address),
      .res      (res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (ex_fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (ex_fire) begin
         rsp_ff <= res;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_ff.status;
   assign rsp_written_value  = rsp_ff.written_value;
   assign rsp_wrote_register = rsp_ff.wrote_register;
   assign rsp_wrote_memory   = rsp_ff.wrote_memory;
   assign rsp_flag_n         = rsp_ff.nzcv[3];
   assign rsp_flag_z         = rsp_ff.nzcv[2];
   assign rsp_flag_c         = rsp_ff.nzcv[1];
   assign rsp_flag_v         = rsp_ff.nzcv[0];

endmodule
